[sv/mch3_pkg.sv]
// Package for the 3D Morton cell hash core: item, config and queue types,
// register index codes, widths and the bit-interleave function.
// Depends on nothing; every other file imports it.
`default_nettype none

package mch3_pkg;

  localparam int CELL_BITS  = 21;
  localparam int POS_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int LIMIT_W    = 22;
  localparam int CODE_W     = 63;
  localparam int PROD_W     = POS_W + SCALE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MID_DEPTH  = 4;
  localparam int MID_PTR_W  = 2;
  localparam int MID_CNT_W  = 3;
  localparam int OUT_DEPTH  = 2;
  localparam int OUT_PTR_W  = 1;
  localparam int OUT_CNT_W  = 2;

  localparam logic signed [POS_W-1:0] ORIGIN_RST = '0;
  localparam logic [SCALE_W-1:0]      SCALE_RST  = 32'd4194304;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST  = 22'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_Z_ORIGIN   = 3'd2,
    CFG_X_SCALE    = 3'd3,
    CFG_Y_SCALE    = 3'd4,
    CFG_Z_SCALE    = 3'd5,
    CFG_CELL_LIMIT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_particle;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic              out_of_range;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_origin;
    logic signed [POS_W-1:0] y_origin;
    logic signed [POS_W-1:0] z_origin;
    logic [SCALE_W-1:0]      x_scale;
    logic [SCALE_W-1:0]      y_scale;
    logic [SCALE_W-1:0]      z_scale;
    logic [LIMIT_W-1:0]      cell_limit;
  } cfg_t;

  // Offset from origin split into sign and magnitude; |pos - origin| < 2^32.
  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] mag;
  } axis_off_t;

  typedef struct packed {
    axis_off_t x;
    axis_off_t y;
    axis_off_t z;
    logic      last;
  } mid_item_t;

  function automatic logic [CODE_W-1:0] interleave3(
    input logic [CELL_BITS-1:0] kx,
    input logic [CELL_BITS-1:0] ky,
    input logic [CELL_BITS-1:0] kz
  );
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = 0; b < CELL_BITS; b++) begin
      code[3*b]   = kx[b];
      code[3*b+1] = ky[b];
      code[3*b+2] = kz[b];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

[sv/mch3_regs.sv]
// Configuration register bank of the Morton cell hash core.
// Depends on mch3_pkg.
`default_nettype none

module mch3_regs (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [mch3_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire  [mch3_pkg::CFG_DATA_W-1:0] cfg_data,
  output mch3_pkg::cfg_t                  cfg
);
  import mch3_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin   <= ORIGIN_RST;
      cfg.y_origin   <= ORIGIN_RST;
      cfg.z_origin   <= ORIGIN_RST;
      cfg.x_scale    <= SCALE_RST;
      cfg.y_scale    <= SCALE_RST;
      cfg.z_scale    <= SCALE_RST;
      cfg.cell_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_X_ORIGIN:   cfg.x_origin   <= cfg_data[POS_W-1:0];
        CFG_Y_ORIGIN:   cfg.y_origin   <= cfg_data[POS_W-1:0];
        CFG_Z_ORIGIN:   cfg.z_origin   <= cfg_data[POS_W-1:0];
        CFG_X_SCALE:    cfg.x_scale    <= cfg_data[SCALE_W-1:0];
        CFG_Y_SCALE:    cfg.y_scale    <= cfg_data[SCALE_W-1:0];
        CFG_Z_SCALE:    cfg.z_scale    <= cfg_data[SCALE_W-1:0];
        CFG_CELL_LIMIT: cfg.cell_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/mch3_front.sv]
// Front end of the Morton cell hash core: origin offset per axis, split into
// sign and magnitude for the back end. Depends on mch3_pkg.
`default_nettype none

module mch3_front (
  input  wire mch3_pkg::in_item_t  item,
  input  wire mch3_pkg::cfg_t      cfg,
  output mch3_pkg::mid_item_t      mid
);
  import mch3_pkg::*;

  function automatic axis_off_t offset(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W-1:0] origin
  );
    logic [POS_W:0] d;
    logic [POS_W:0] nd;
    axis_off_t      o;
    d     = {pos[POS_W-1], pos} - {origin[POS_W-1], origin};
    nd    = {origin[POS_W-1], origin} - {pos[POS_W-1], pos};
    o.neg = d[POS_W];
    o.mag = d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
    return o;
  endfunction

  always_comb begin
    mid.x    = offset(item.pos_x, cfg.x_origin);
    mid.y    = offset(item.pos_y, cfg.y_origin);
    mid.z    = offset(item.pos_z, cfg.z_origin);
    mid.last = item.last_particle;
  end

endmodule

`default_nettype wire

[sv/mch3_queue.sv]
// Short queue between front and back ends of the Morton cell hash core.
// Depends on mch3_pkg.
`default_nettype none

module mch3_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr,
  input  wire mch3_pkg::mid_item_t wdata,
  output logic                 full,
  input  wire                  rd,
  output logic                 valid,
  output mch3_pkg::mid_item_t  head
);
  import mch3_pkg::*;

  mid_item_t            q [MID_DEPTH];
  logic [MID_PTR_W-1:0] wp;
  logic [MID_PTR_W-1:0] rp;
  logic [MID_CNT_W-1:0] cnt;

  assign full  = (cnt == MID_CNT_W'(MID_DEPTH));
  assign valid = (cnt != '0);
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= wdata;
  end

endmodule

`default_nettype wire

[sv/mch3_back.sv]
// Back end of the Morton cell hash core: per-axis scale multiply, range
// check, bit interleave and result queue. Depends on mch3_pkg.
`default_nettype none

module mch3_back (
  input  wire                      clk,
  input  wire                      rst,
  input  wire mch3_pkg::cfg_t      cfg,
  input  wire                      in_valid,
  input  wire mch3_pkg::mid_item_t in_head,
  output logic                     in_pop,
  output logic                     empty,
  input  wire                      pop,
  output mch3_pkg::out_item_t      result
);
  import mch3_pkg::*;

  logic              m_valid;
  logic [PROD_W-1:0] m_px;
  logic [PROD_W-1:0] m_py;
  logic [PROD_W-1:0] m_pz;
  logic [2:0]        m_neg;
  logic              m_last;
  logic              m_adv;
  logic              load;

  out_item_t            oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owp;
  logic [OUT_PTR_W-1:0] orp;
  logic [OUT_CNT_W-1:0] ocnt;
  logic                 pop_fire;
  out_item_t            res_next;
  logic                 ok_x;
  logic                 ok_y;
  logic                 ok_z;

  function automatic logic axis_good(
    input logic                neg,
    input logic [SCALE_W-1:0]  k,
    input logic [LIMIT_W-1:0]  lim
  );
    return !(neg && (k != '0)) && (k < SCALE_W'(lim)) &&
           (k[SCALE_W-1:CELL_BITS] == '0);
  endfunction

  assign pop_fire = pop && !empty;
  assign empty    = (ocnt == '0);
  assign result   = oq[orp];
  assign m_adv    = m_valid && ((ocnt != OUT_CNT_W'(OUT_DEPTH)) || pop_fire);
  assign load     = in_valid && (!m_valid || m_adv);
  assign in_pop   = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_adv) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_px   <= PROD_W'(in_head.x.mag) * PROD_W'(cfg.x_scale);
      m_py   <= PROD_W'(in_head.y.mag) * PROD_W'(cfg.y_scale);
      m_pz   <= PROD_W'(in_head.z.mag) * PROD_W'(cfg.z_scale);
      m_neg  <= {in_head.z.neg, in_head.y.neg, in_head.x.neg};
      m_last <= in_head.last;
    end
  end

  always_comb begin
    ok_x = axis_good(m_neg[0], m_px[PROD_W-1:POS_W], cfg.cell_limit);
    ok_y = axis_good(m_neg[1], m_py[PROD_W-1:POS_W], cfg.cell_limit);
    ok_z = axis_good(m_neg[2], m_pz[PROD_W-1:POS_W], cfg.cell_limit);
    res_next.out_of_range = !(ok_x && ok_y && ok_z);
    res_next.last_result  = m_last;
    res_next.cell_code    = res_next.out_of_range ? '0 :
      interleave3(m_px[POS_W+CELL_BITS-1:POS_W],
                  m_py[POS_W+CELL_BITS-1:POS_W],
                  m_pz[POS_W+CELL_BITS-1:POS_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (m_adv)    owp <= owp + 1'b1;
      if (pop_fire) orp <= orp + 1'b1;
      case ({m_adv, pop_fire})
        2'b10:   ocnt <= ocnt + 1'b1;
        2'b01:   ocnt <= ocnt - 1'b1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) oq[owp] <= res_next;
  end

endmodule

`default_nettype wire

[sv/morton_cell_hash_3d_core.sv]
// Top level of the 3D Morton cell hash core: register bank, front end,
// mid queue and back end. Depends on mch3_pkg and the mch3_* modules.
//
// Takes one particle position per cycle while not full and returns one result
// per position in order: one item per clock sustained while results are popped,
// limited by one 32x32 multiplier per axis in the back end. A result passes the
// offset into the mid queue, the multiply stage and the result queue in order,
// then waits on the result ports until popped. The front end keeps accepting
// while results wait, until the four-entry mid queue fills. Configuration
// writes take effect on the next cycle.
`default_nettype none

module morton_cell_hash_3d_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             push,
  output logic                            full,
  input  wire mch3_pkg::in_item_t         item,
  output logic                            empty,
  input  wire                             pop,
  output mch3_pkg::out_item_t             result,
  input  wire                             cfg_we,
  input  wire  [mch3_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire  [mch3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mch3_pkg::*;

  cfg_t      cfg;
  mid_item_t mid_in;
  mid_item_t mid_head;
  logic      mid_valid;
  logic      mid_pop;
  logic      accept;

  assign accept = push && !full;

  mch3_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  mch3_front u_front (
    .item (item),
    .cfg  (cfg),
    .mid  (mid_in)
  );

  mch3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (mid_in),
    .full  (full),
    .rd    (mid_pop),
    .valid (mid_valid),
    .head  (mid_head)
  );

  mch3_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (mid_valid),
    .in_head  (mid_head),
    .in_pop   (mid_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

[sv/mch3_checker.sv]
// Port-level checker for the 3D Morton cell hash core and its bind.
// Depends on mch3_pkg and morton_cell_hash_3d_core.
`default_nettype none

module mch3_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             push,
  input wire                             full,
  input wire mch3_pkg::in_item_t         item,
  input wire                             empty,
  input wire                             pop,
  input wire mch3_pkg::out_item_t        result,
  input wire                             cfg_we,
  input wire  [mch3_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input wire  [mch3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mch3_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting transaction changed or dropped");

  a_flag_zero_code: assert property (@(posedge clk) disable iff (rst)
    !empty && result.out_of_range |-> result.cell_code == '0)
    else $error("out of range result carries nonzero cell code");

  a_item_known: assert property (@(posedge clk) disable iff (rst)
    push && !full |-> !$isunknown(item))
    else $error("accepted transaction carries unknown bits");

  a_cfg_known: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !$isunknown({cfg_idx, cfg_data}))
    else $error("register write carries unknown bits");

endmodule

bind morton_cell_hash_3d_core mch3_checker u_chk (.*);

`default_nettype wire

[dv/morton_cell_hash_3d_core_test.sv]
// Self-checking bench for morton_cell_hash_3d_core: a directed table, then random
// positions over a series of register settings, checked against a local binning model.
// Depends on mch3_pkg and the core RTL.
`timescale 1ns / 1ps

module morton_cell_hash_3d_core_test;
  import mch3_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_COUNT = 9;
  localparam int ITEMS_PER_PHASE = 82;
  localparam int PROBE_COUNT = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    in_item_t  pos;
    logic      typed;
    out_item_t want;
  } probe_row_t;

  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{63'h0, 1'b0, 1'b0}},
    '{'{32'h0000_0400, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{63'h1, 1'b0, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0400, 32'h0000_0000, 1'b0}, 1'b1, '{63'h2, 1'b0, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0400, 1'b1}, 1'b1, '{63'h4, 1'b0, 1'b1}},
    '{'{32'h0000_FC00, 32'h0000_FC00, 32'h0000_FC00, 1'b1}, 1'b1, '{63'h3FFFF, 1'b0, 1'b1}},
    '{'{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{63'h9249, 1'b0, 1'b0}},
    '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1}, 1'b1, '{63'h0, 1'b1, 1'b1}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FC01, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{63'h0, 1'b0, 1'b1}},
    '{'{32'hFFFF_FC00, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'h0000_0000, 32'hFFFF_FC00, 32'h0000_0000, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FC00, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1, '{63'h0, 1'b1, 1'b1}},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b1, '{63'h0, 1'b1, 1'b0}},
    '{'{32'h0000_1400, 32'h0000_0C07, 32'h0000_9C40, 1'b1}, 1'b0, '0},
    '{'{32'h0000_03FF, 32'h0000_07FF, 32'h0000_8235, 1'b0}, 1'b0, '0},
    '{'{32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 1'b1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [POS_W-1:0] origin [3];
  logic [SCALE_W-1:0] scale [3];
  logic [LIMIT_W-1:0] cell_limit;

  out_item_t bins_due [$];
  int mismatches = 0;
  int idle_pct = 20;
  int cycle_count = 0;

  morton_cell_hash_3d_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t predict_bin(input in_item_t p);
    logic [POS_W-1:0] pos [3];
    logic [CELL_BITS-1:0] bin_idx [3];
    logic signed [POS_W:0] off;
    logic [POS_W:0] mag;
    logic [PROD_W:0] prod;
    logic [POS_W:0] k;
    logic bad;
    out_item_t r;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    bad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      off = {pos[a][POS_W-1], pos[a]} - {origin[a][POS_W-1], origin[a]};
      mag = off[POS_W] ? -off : off;
      prod = mag * scale[a];
      k = prod[PROD_W:SCALE_W];
      if ((off[POS_W] && k != 0) || k >= cell_limit || k >= (33'd1 << CELL_BITS))
        bad = 1'b1;
      bin_idx[a] = k[CELL_BITS-1:0];
    end
    r.cell_code = '0;
    if (!bad) begin
      for (int b = CELL_BITS - 1; b >= 0; b--)
        r.cell_code = {r.cell_code[CODE_W-4:0], bin_idx[2][b], bin_idx[1][b], bin_idx[0][b]};
    end
    r.out_of_range = bad;
    r.last_result = p.last_particle;
    return r;
  endfunction

  function automatic void check_bin(input out_item_t want, input out_item_t got);
    if (got.cell_code !== want.cell_code) begin
      $display("%0t: cell_code expected %h actual %h", $time, want.cell_code, got.cell_code);
      mismatches++;
    end
    if (got.out_of_range !== want.out_of_range) begin
      $display("%0t: out_of_range expected %b actual %b", $time, want.out_of_range,
               got.out_of_range);
      mismatches++;
    end
    if (got.last_result !== want.last_result) begin
      $display("%0t: last_result expected %b actual %b", $time, want.last_result,
               got.last_result);
      mismatches++;
    end
  endfunction

  // Aim most positions inside the grid, some at its far edge, some just below the origin.
  function automatic logic [POS_W-1:0] aim_axis(input int a);
    longint unsigned span;
    longint unsigned off;
    logic [LIMIT_W-1:0] lim;
    int pick;
    pick = $urandom_range(99);
    lim = (cell_limit > 22'h20_0000) ? 22'h20_0000 : cell_limit;
    if (scale[a] == 0 || pick >= 90)
      return $urandom;
    if (pick < 10)
      return origin[a] - $urandom_range(0, 70000);
    span = (longint'(lim) << 32) / scale[a];
    if (span > 64'h1_0000_0000)
      span = 64'h1_0000_0000;
    if (pick < 20)
      off = span - 1 + $urandom_range(0, 2);
    else if (span == 0)
      off = 0;
    else
      off = {$urandom, $urandom} % span;
    return origin[a] + off[POS_W-1:0];
  endfunction

  task automatic offer_position(input in_item_t pos, input out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= pos;
    @(posedge clk);
    while (full)
      @(posedge clk);
    bins_due.push_back(want);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_X_ORIGIN:   origin[0] = data;
      CFG_Y_ORIGIN:   origin[1] = data;
      CFG_Z_ORIGIN:   origin[2] = data;
      CFG_X_SCALE:    scale[0] = data;
      CFG_Y_SCALE:    scale[1] = data;
      CFG_Z_SCALE:    scale[2] = data;
      CFG_CELL_LIMIT: cell_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_bins();
    push <= 1'b0;
    while (bins_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (bins_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %h", $time, result);
          mismatches++;
        end else begin
          check_bin(bins_due.pop_front(), result);
        end
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("morton_cell_hash_3d_core test failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] org_plan [3];
    logic [CFG_DATA_W-1:0] scl_plan [3];
    logic [CFG_DATA_W-1:0] lim_plan;
    in_item_t pos;
    for (int a = 0; a < 3; a++) begin
      origin[a] = ORIGIN_RST;
      scale[a] = SCALE_RST;
    end
    cell_limit = LIMIT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < PROBE_COUNT; n++)
      offer_position(PROBES[n].pos,
                     PROBES[n].typed ? PROBES[n].want : predict_bin(PROBES[n].pos));

    for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
      drain_bins();
      idle_pct = (phase == 5) ? 0 : 20;
      for (int a = 0; a < 3; a++) begin
        case (phase)
          1: begin
            org_plan[a] = $urandom;
            scl_plan[a] = 32'h0040_0000 >> $urandom_range(0, 6);
          end
          2: begin
            org_plan[a] = 32'h8000_0000;
            scl_plan[a] = 32'hFFFF_FFFF;
          end
          3: begin
            org_plan[a] = 32'h7FFF_FFFF;
            scl_plan[a] = (a == 0) ? 32'h0 : (a == 1) ? 32'h1 : 32'h0001_0000;
          end
          4: begin
            org_plan[a] = $urandom;
            scl_plan[a] = $urandom >> $urandom_range(8, 20);
          end
          5: begin
            org_plan[a] = 32'h0;
            scl_plan[a] = 32'h0001_0000;
          end
          default: begin
            org_plan[a] = $urandom;
            scl_plan[a] = $urandom >> $urandom_range(0, 31);
          end
        endcase
      end
      case (phase)
        1: lim_plan = 32'h0020_0000;
        2: lim_plan = 32'hFFFF_FFFF;
        3: lim_plan = 32'h0000_0001;
        4: lim_plan = {10'($urandom), 22'h0};
        5: lim_plan = 32'h001F_FFFF;
        PHASE_COUNT: lim_plan = $urandom;
        default: lim_plan = {10'($urandom), 22'($urandom_range(1, 22'h20_0000))};
      endcase
      write_register(CFG_X_ORIGIN, org_plan[0]);
      write_register(CFG_Y_ORIGIN, org_plan[1]);
      write_register(CFG_Z_ORIGIN, org_plan[2]);
      write_register(CFG_X_SCALE, scl_plan[0]);
      write_register(CFG_Y_SCALE, scl_plan[1]);
      write_register(CFG_Z_SCALE, scl_plan[2]);
      write_register(CFG_CELL_LIMIT, lim_plan);
      write_register(CFG_SPARE, $urandom);
      cfg_we <= 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pos.pos_x = aim_axis(0);
        pos.pos_y = aim_axis(1);
        pos.pos_z = aim_axis(2);
        pos.last_particle = 1'($urandom_range(1));
        offer_position(pos, predict_bin(pos));
      end
    end

    drain_bins();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("morton_cell_hash_3d_core test passed");
    else
      $display("morton_cell_hash_3d_core test failed");
    $finish;
  end

endmodule
